@@ sv/nj_pkg.sv @@
// Package for the neighbor-joining engine.
// Holds the sequencer state type. No dependencies.
package nj_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_SC_RD,
        S_SC_D1,
        S_SC_D2,
        S_SC_DIV,
        S_SC_CMP,
        S_BR_START,
        S_BR_DIV,
        S_BR_FIN,
        S_UP_RA,
        S_UP_RB,
        S_UP_WR,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

endpackage

@@ sv/neighbor_joining_step.sv @@
// Neighbor-joining engine: triangular distance memory, row-sum memory,
// one shared radix-2 divider under a sequencer.
// Depends on nj_pkg.
//
// Usage: raise start with action, indices and distance while busy is low.
// A load (action 0) writes one distance entry in the request cycle when the two
// indices differ and lie below MAX_CLUSTERS, resets the live count to cluster_count
// and leaves busy low. A join (action 1) raises busy and ends with a one-cycle o_done
// strobe carrying the pair, both branch lengths, the degree and the remaining count.
// A join sums the rows, scans every pair with one division each through the shared
// divider (W = 50 + log2(MAX_CLUSTERS) bits), divides once more for the branch
// lengths, merges the pair into its lower index and shifts out the higher one; the
// pair scan dominates its run time. A join with one cluster or fewer leaves busy low
// and answers in the cycle after the request, with o_no_join set.
// cluster_count may be written at any time through i_cfg_we/i_cfg_wdata
// and is clamped to 2..MAX_CLUSTERS. Reset clears the sequencer and sets
// cluster_count and the live count to the smaller of 32 and MAX_CLUSTERS. Distance
// entries are undefined until loaded. Results cannot be stalled by the receiver.
module neighbor_joining_step
    import nj_pkg::*;
#(
    parameter int MAX_CLUSTERS = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [4:0]         i_first_cluster,
    input  logic [4:0]         i_second_cluster,
    input  logic [15:0]        i_distance_value,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    output logic               o_done,
    output logic [4:0]         o_joined_low,
    output logic [4:0]         o_joined_high,
    output logic signed [47:0] o_branch_low,
    output logic signed [47:0] o_branch_high,
    output logic signed [47:0] o_min_degree,
    output logic [5:0]         o_remaining,
    output logic               o_no_join
);

    localparam int IW    = $clog2(MAX_CLUSTERS);
    localparam int CW    = $clog2(MAX_CLUSTERS + 1);
    localparam int DEPTH = MAX_CLUSTERS * (MAX_CLUSTERS - 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = 48 + IW + 1;
    localparam int NW    = SUMW + 1;
    localparam int WW    = NW + 1;
    localparam int DVW   = IW + 1;
    localparam int KW    = $clog2(NW + 1);
    localparam int RST_CNT = (MAX_CLUSTERS < 32) ? MAX_CLUSTERS : 32;
    localparam logic signed [WW-1:0] SMAX = {{(WW-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [WW-1:0] SMIN = ~SMAX;

    function automatic logic [AW-1:0] f_slot(input logic [IW-1:0] x, input logic [IW-1:0] y);
        logic [IW-1:0]   lo;
        logic [IW-1:0]   hi;
        logic [2*IW-1:0] prod;
        lo   = (x < y) ? x : y;
        hi   = (x < y) ? y : x;
        prod = {{IW{1'b0}}, hi} * {{IW{1'b0}}, hi - IW'(1)};
        return AW'(prod >> 1) + AW'(lo);
    endfunction

    function automatic logic signed [47:0] f_sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] t;
        t = v;
        if (v > SMAX) t = SMAX;
        if (v < SMIN) t = SMIN;
        return t[47:0];
    endfunction

    function automatic logic signed [WW-1:0] f_half(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] t;
        t = v + $signed({{(WW-1){1'b0}}, v[WW-1]});
        return t >>> 1;
    endfunction

    t_state r_state, n_state;
    logic [CW-1:0] r_cfg, n_cfg, r_live, n_live;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_p, n_p, r_q, n_q, r_a, n_a, r_b, n_b;
    logic signed [SUMW-1:0] r_acc, n_acc, r_rp, n_rp, r_rq, n_rq;
    logic signed [SUMW-1:0] r_bra, n_bra, r_brb, n_brb;
    logic signed [47:0] r_d, n_d, r_best, n_best, r_bd, n_bd, r_x, n_x;
    logic signed [47:0] r_bl, n_bl, r_bh, n_bh;
    logic [NW-1:0]  r_dq, n_dq;
    logic [DVW-1:0] r_drem, n_drem, r_dv, n_dv;
    logic [KW-1:0]  r_dcnt, n_dcnt;
    logic           r_dneg, n_dneg;
    logic           r_done, n_done, r_nojoin, n_nojoin;
    logic [4:0]     r_olo, n_olo, r_ohi, n_ohi;
    logic signed [47:0] r_obl, n_obl, r_obh, n_obh, r_odeg, n_odeg;
    logic [5:0]     r_orem, n_orem;

    // memories
    logic signed [47:0]   r_mem [DEPTH];
    logic signed [SUMW-1:0] r_rsum [MAX_CLUSTERS];
    logic signed [47:0]   mem_rd;
    logic signed [SUMW-1:0] rs_rd;
    logic [AW-1:0]        mem_ra, mem_wa;
    logic                 mem_we;
    logic signed [47:0]   mem_wd;
    logic [IW-1:0]        rs_ra;
    logic                 rs_we;
    logic signed [SUMW-1:0] rs_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        mem_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rsum[r_i] <= rs_wd;
        end
        rs_rd <= r_rsum[rs_ra];
    end

    logic [IW-1:0] nm1, nm2;
    logic          gt2;
    logic [DVW:0]  rem_sh;
    logic          ge;
    logic signed [NW-1:0] quot, num;
    logic signed [WW-1:0] wide, half;
    logic signed [47:0]   deg, bl_v;
    logic signed [SUMW-1:0] acc_n;
    logic [IW-1:0] op;
    logic          ld_ok;

    assign nm1    = IW'(r_live - CW'(1));
    assign nm2    = IW'(r_live - CW'(2));
    assign gt2    = r_live > CW'(2);
    assign rem_sh = {r_drem, r_dq[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_dv};
    assign quot   = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    assign ld_ok  = (i_first_cluster != i_second_cluster)
                 && (int'(i_first_cluster) < MAX_CLUSTERS)
                 && (int'(i_second_cluster) < MAX_CLUSTERS);

    always_comb begin
        n_state = r_state; n_cfg = r_cfg; n_live = r_live;
        n_i = r_i; n_j = r_j; n_p = r_p; n_q = r_q; n_a = r_a; n_b = r_b;
        n_acc = r_acc; n_rp = r_rp; n_rq = r_rq; n_bra = r_bra; n_brb = r_brb;
        n_d = r_d; n_best = r_best; n_bd = r_bd; n_x = r_x; n_bl = r_bl; n_bh = r_bh;
        n_dq = r_dq; n_drem = r_drem; n_dv = r_dv; n_dcnt = r_dcnt; n_dneg = r_dneg;
        n_done = 1'b0; n_nojoin = r_nojoin; n_olo = r_olo; n_ohi = r_ohi;
        n_obl = r_obl; n_obh = r_obh; n_odeg = r_odeg; n_orem = r_orem;
        mem_ra = '0; mem_wa = '0; mem_we = 1'b0; mem_wd = '0;
        rs_ra = '0; rs_we = 1'b0; rs_wd = '0;
        num = '0; wide = '0; half = '0; deg = '0; bl_v = '0; acc_n = '0; op = '0;

        if (i_cfg_we) begin
            if (i_cfg_wdata < 6'd2) begin
                n_cfg = CW'(2);
            end else if (int'(i_cfg_wdata) > MAX_CLUSTERS) begin
                n_cfg = CW'(MAX_CLUSTERS);
            end else begin
                n_cfg = CW'(i_cfg_wdata);
            end
        end

        // divider step, shared by scan and branch
        if (r_state == S_SC_DIV || r_state == S_BR_DIV) begin
            n_drem = ge ? DVW'(rem_sh - {1'b0, r_dv}) : DVW'(rem_sh);
            n_dq   = {r_dq[NW-2:0], ge};
            n_dcnt = r_dcnt - KW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (start && !i_action) begin
                    n_live = r_cfg;
                    if (ld_ok) begin
                        mem_we = 1'b1;
                        mem_wa = f_slot(IW'(i_first_cluster), IW'(i_second_cluster));
                        mem_wd = $signed(48'(i_distance_value) << FRAC_BITS);
                    end
                end else if (start && i_action) begin
                    if (r_live <= CW'(1)) begin
                        n_done = 1'b1; n_nojoin = 1'b1;
                        n_olo = '0; n_ohi = '0; n_obl = '0; n_obh = '0; n_odeg = '0;
                        n_orem = 6'(r_live);
                    end else begin
                        n_i = '0; n_j = '0; n_acc = '0;
                        n_state = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                mem_ra  = f_slot(r_i, r_j);
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                acc_n = r_acc + ((r_i != r_j) ? SUMW'(mem_rd) : '0);
                n_state = S_SUM_RD;
                if (r_j == nm1) begin
                    rs_we = 1'b1; rs_wd = acc_n;
                    n_acc = '0; n_j = '0;
                    if (r_i == nm1) begin
                        n_p = '0; n_q = IW'(1);
                        n_state = S_SC_RD;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_acc = acc_n;
                    n_j = r_j + IW'(1);
                end
            end
            S_SC_RD: begin
                mem_ra = f_slot(r_p, r_q);
                rs_ra  = r_p;
                n_state = S_SC_D1;
            end
            S_SC_D1: begin
                n_d  = mem_rd;
                n_rp = rs_rd;
                rs_ra = r_q;
                n_state = S_SC_D2;
            end
            S_SC_D2: begin
                num = NW'(r_rp) + NW'(rs_rd);
                n_dneg = num[NW-1];
                n_dq   = num[NW-1] ? -num : num;
                n_drem = '0;
                n_dv   = DVW'(r_live) - DVW'(2);
                n_dcnt = KW'(NW);
                n_rq   = rs_rd;
                if (gt2) begin
                    n_state = S_SC_DIV;
                end else begin
                    n_dq = '0; n_dneg = 1'b0;
                    n_state = S_SC_CMP;
                end
            end
            S_SC_DIV: begin
                if (r_dcnt == KW'(1)) n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                wide = WW'(r_d) - WW'(quot);
                deg  = f_sat(wide);
                if ((r_p == '0 && r_q == IW'(1)) || deg < r_best) begin
                    n_best = deg; n_a = r_p; n_b = r_q; n_bd = r_d;
                    n_bra = r_rp; n_brb = r_rq;
                end
                n_state = S_SC_RD;
                if (r_q == nm1) begin
                    if (r_p == nm2) begin
                        n_state = S_BR_START;
                    end else begin
                        n_p = r_p + IW'(1);
                        n_q = r_p + IW'(2);
                    end
                end else begin
                    n_q = r_q + IW'(1);
                end
            end
            S_BR_START: begin
                num = NW'(r_bra) - NW'(r_brb);
                n_dneg = num[NW-1];
                n_dq   = num[NW-1] ? -num : num;
                n_drem = '0;
                n_dv   = (DVW'(r_live) - DVW'(2)) << 1;
                n_dcnt = KW'(NW);
                if (gt2) begin
                    n_state = S_BR_DIV;
                end else begin
                    n_dq = '0; n_dneg = 1'b0;
                    n_state = S_BR_FIN;
                end
            end
            S_BR_DIV: begin
                if (r_dcnt == KW'(1)) n_state = S_BR_FIN;
            end
            S_BR_FIN: begin
                half = f_half(WW'(r_bd));
                bl_v = f_sat(half + WW'(quot));
                n_bl = bl_v;
                n_bh = f_sat(WW'(r_bd) - WW'(bl_v));
                n_i  = '0;
                n_state = S_UP_RA;
            end
            S_UP_RA: begin
                mem_ra = f_slot(r_a, r_i);
                if (r_i == r_a || r_i == r_b) begin
                    if (r_i == nm1) begin
                        n_p = '0; n_q = r_b;
                        n_state = (r_b == nm1) ? S_DONE : S_SH_RD;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_state = S_UP_RB;
                end
            end
            S_UP_RB: begin
                n_x = mem_rd;
                mem_ra = f_slot(r_i, r_b);
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                wide   = WW'(r_x) + WW'(mem_rd) - WW'(r_bd);
                mem_we = 1'b1;
                mem_wa = f_slot(r_a, r_i);
                mem_wd = f_sat(f_half(wide));
                n_state = S_UP_RA;
                if (r_i == nm1) begin
                    n_p = '0; n_q = r_b;
                    n_state = (r_b == nm1) ? S_DONE : S_SH_RD;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_SH_RD: begin
                op = (r_p < r_b) ? r_p : r_p + IW'(1);
                mem_ra = f_slot(op, r_q + IW'(1));
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                mem_wa = f_slot(r_p, r_q);
                mem_wd = mem_rd;
                n_state = S_SH_RD;
                if (r_p == r_q - IW'(1)) begin
                    if (r_q == nm2) begin
                        n_state = S_DONE;
                    end else begin
                        n_q = r_q + IW'(1);
                        n_p = '0;
                    end
                end else begin
                    n_p = r_p + IW'(1);
                end
            end
            S_DONE: begin
                n_live = r_live - CW'(1);
                n_done = 1'b1; n_nojoin = 1'b0;
                n_olo = 5'(r_a); n_ohi = 5'(r_b);
                n_obl = r_bl; n_obh = r_bh; n_odeg = r_best;
                n_orem = 6'(r_live - CW'(1));
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CW'(RST_CNT);
            r_live  <= CW'(RST_CNT);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_live  <= n_live;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_p <= n_p; r_q <= n_q; r_a <= n_a; r_b <= n_b;
        r_acc <= n_acc; r_rp <= n_rp; r_rq <= n_rq; r_bra <= n_bra; r_brb <= n_brb;
        r_d <= n_d; r_best <= n_best; r_bd <= n_bd; r_x <= n_x;
        r_bl <= n_bl; r_bh <= n_bh;
        r_dq <= n_dq; r_drem <= n_drem; r_dv <= n_dv; r_dcnt <= n_dcnt; r_dneg <= n_dneg;
        r_nojoin <= n_nojoin; r_olo <= n_olo; r_ohi <= n_ohi;
        r_obl <= n_obl; r_obh <= n_obh; r_odeg <= n_odeg; r_orem <= n_orem;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_joined_low  = r_olo;
    assign o_joined_high = r_ohi;
    assign o_branch_low  = r_obl;
    assign o_branch_high = r_obh;
    assign o_min_degree  = r_odeg;
    assign o_remaining   = r_orem;
    assign o_no_join     = r_nojoin;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_done && !o_no_join)
        else $error("join end without result strobe");

    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live >= CW'(1) && int'(r_live) <= MAX_CLUSTERS)
        else $error("live count out of range");

    a_nojoin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_no_join |-> o_remaining <= 6'd1)
        else $error("no_join with clusters left");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_no_join && MAX_CLUSTERS <= 32) |-> o_joined_low < o_joined_high)
        else $error("joined pair out of order");

endmodule

@@ verif/neighbor_joining_step_tb.sv @@
// Testbench for neighbor_joining_step: a directed table, then random distance sets,
// checked against a built-in fixed-point neighbor-joining predictor.
// Depends on nj_pkg and neighbor_joining_step.
`timescale 1ns / 100ps

module neighbor_joining_step_tb;
    import nj_pkg::*;

    localparam int NCL = 32;
    localparam int DEPTH = NCL * (NCL - 1) / 2;
    localparam int IDLE_LIMIT = 200000;
    localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -S48_MAX - 1;

    typedef enum logic [1:0] {ROW_LOAD, ROW_JOIN, ROW_CFG} t_row_kind;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_JOIN = 1'b1;

    typedef struct packed {
        logic [4:0]         lo;
        logic [4:0]         hi;
        logic signed [47:0] br_lo;
        logic signed [47:0] br_hi;
        logic signed [47:0] degree;
        logic [5:0]         remaining;
        logic               no_join;
    } t_join_result;

    typedef struct {
        t_row_kind    kind;
        int           f;
        int           s;
        int           val;
        bit           typed;
        t_join_result res;
    } t_row;

    localparam logic signed [47:0] D_MAX = 48'sh0000_FFFF_0000;
    localparam t_join_result JOIN_MAX2 = '{5'd0, 5'd1, 48'sh7FFF8000, 48'sh7FFF8000,
                                          D_MAX, 6'd1, 1'b0};
    localparam t_join_result JOIN_NONE1 = '{5'd0, 5'd0, 48'sd0, 48'sd0, 48'sd0,
                                           6'd1, 1'b1};

    logic i_clk, i_rst_n;
    logic start, busy;
    logic i_action;
    logic [4:0] i_first_cluster, i_second_cluster;
    logic [15:0] i_distance_value;
    logic i_cfg_we;
    logic [5:0] i_cfg_wdata;
    logic o_done;
    logic [4:0] o_joined_low, o_joined_high;
    logic signed [47:0] o_branch_low, o_branch_high, o_min_degree;
    logic [5:0] o_remaining;
    logic o_no_join;

    neighbor_joining_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_first_cluster(i_first_cluster),
        .i_second_cluster(i_second_cluster), .i_distance_value(i_distance_value),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done),
        .o_joined_low(o_joined_low), .o_joined_high(o_joined_high),
        .o_branch_low(o_branch_low), .o_branch_high(o_branch_high),
        .o_min_degree(o_min_degree), .o_remaining(o_remaining),
        .o_no_join(o_no_join)
    );

    // predictor state
    longint dist_mem[DEPTH];
    longint row_total[NCL];
    int unsigned live_n, cfg_n;

    t_join_result pending_joins[$];
    int requests_sent;
    int idle_pct;
    int idle_cycles;
    bit failed;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned tri_slot(int unsigned p, int unsigned q);
        int unsigned lo, hi;
        lo = p < q ? p : q;
        hi = p < q ? q : p;
        return hi * (hi - 1) / 2 + lo;
    endfunction

    function automatic longint sat48(longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    function automatic void total_rows(int unsigned n);
        for (int i = 0; i < NCL; i++) row_total[i] = 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (i != j) row_total[i] += dist_mem[tri_slot(i, j)];
    endfunction

    function automatic void apply_load(int f, int s, int val);
        live_n = cfg_n;
        if (f != s) dist_mem[tri_slot(f, s)] = longint'(val) <<< 16;
    endfunction

    function automatic t_join_result join_once();
        t_join_result r;
        longint best, deg, d, bl, bh;
        longint moved[DEPTH];
        int unsigned n, a, b, op, oq;
        r = '0;
        n = live_n;
        if (n <= 1) begin
            r.remaining = n[5:0];
            r.no_join = 1'b1;
            return r;
        end
        total_rows(n);
        a = 0; b = 1; best = 0;
        for (int unsigned p = 0; p + 1 < n; p++) begin
            for (int unsigned q = p + 1; q < n; q++) begin
                deg = dist_mem[tri_slot(p, q)];
                if (n > 2) deg -= (row_total[p] + row_total[q]) / longint'(n - 2);
                deg = sat48(deg);
                if ((p == 0 && q == 1) || deg < best) begin
                    best = deg; a = p; b = q;
                end
            end
        end
        d = dist_mem[tri_slot(a, b)];
        bl = d / 2;
        if (n > 2) bl += (row_total[a] - row_total[b]) / longint'(2 * (n - 2));
        bl = sat48(bl);
        bh = sat48(d - bl);
        for (int unsigned i = 0; i < n; i++) begin
            if (i != a && i != b)
                dist_mem[tri_slot(a, i)] = sat48((dist_mem[tri_slot(a, i)]
                    + dist_mem[tri_slot(i, b)] - d) / 2);
        end
        moved = dist_mem;
        for (int unsigned q = 1; q + 1 < n; q++) begin
            for (int unsigned p = 0; p < q; p++) begin
                op = p < b ? p : p + 1;
                oq = q < b ? q : q + 1;
                dist_mem[tri_slot(p, q)] = moved[tri_slot(op, oq)];
            end
        end
        live_n = n - 1;
        total_rows(live_n);
        r.lo = a[4:0];
        r.hi = b[4:0];
        r.br_lo = bl[47:0];
        r.br_hi = bh[47:0];
        r.degree = best[47:0];
        r.remaining = live_n[5:0];
        return r;
    endfunction

    task automatic send_request(logic act, int f, int s, int val, bit typed,
                                t_join_result typed_res);
        t_join_result r;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_first_cluster <= f[4:0];
        i_second_cluster <= s[4:0];
        i_distance_value <= val[15:0];
        do @(posedge i_clk); while (busy !== 1'b0);
        requests_sent++;
        if (act == ACT_LOAD) begin
            apply_load(f, s, val);
        end else begin
            r = join_once();
            pending_joins.push_back(typed ? typed_res : r);
        end
    endtask

    task automatic load(int f, int s, int val);
        send_request(ACT_LOAD, f, s, val, 1'b0, '0);
    endtask

    task automatic join_req();
        send_request(ACT_JOIN, 0, 0, 0, 1'b0, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_joins.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(int val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_n = val < 2 ? 2 : (val > NCL ? NCL : val);
    endtask

    function automatic int rand_dist();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(15);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // full matrix for the configured count, random order of the two indices, plus occasional equal-index loads
    task automatic load_set();
        for (int q = 1; q < cfg_n; q++)
            for (int p = 0; p < q; p++) begin
                if ($urandom_range(1)) load(p, q, rand_dist());
                else load(q, p, rand_dist());
                if ($urandom_range(19) == 0) begin
                    int k;
                    k = $urandom_range(31);
                    load(k, k, $urandom_range(65535));
                end
            end
    endtask

    task automatic run_set(int count_val, int max_joins);
        int joins;
        write_count(count_val);
        load_set();
        joins = $urandom_range(1, max_joins);
        for (int j = 0; j < joins; j++) begin
            join_req();
            if ($urandom_range(7) == 0) begin
                int p, q;
                p = $urandom_range(cfg_n - 1);
                q = $urandom_range(cfg_n - 1);
                load(p, q, rand_dist());
            end
        end
    endtask

    t_row dir_rows[$];

    task automatic add_row(t_row_kind k, int f, int s, int val, bit typed = 1'b0,
                           t_join_result res = '0);
        t_row r;
        r.kind = k; r.f = f; r.s = s; r.val = val; r.typed = typed; r.res = res;
        dir_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_joins.size() == 0) begin
                $error("unexpected result: pair %0d/%0d", o_joined_low, o_joined_high);
                failed = 1'b1;
            end else begin
                t_join_result e;
                e = pending_joins.pop_front();
                if (o_joined_low !== e.lo) begin
                    $error("joined_low exp %0d got %0d", e.lo, o_joined_low); failed = 1'b1;
                end
                if (o_joined_high !== e.hi) begin
                    $error("joined_high exp %0d got %0d", e.hi, o_joined_high); failed = 1'b1;
                end
                if (o_branch_low !== e.br_lo) begin
                    $error("branch_low exp %0d got %0d", e.br_lo, o_branch_low); failed = 1'b1;
                end
                if (o_branch_high !== e.br_hi) begin
                    $error("branch_high exp %0d got %0d", e.br_hi, o_branch_high);
                    failed = 1'b1;
                end
                if (o_min_degree !== e.degree) begin
                    $error("min_degree exp %0d got %0d", e.degree, o_min_degree);
                    failed = 1'b1;
                end
                if (o_remaining !== e.remaining) begin
                    $error("remaining exp %0d got %0d", e.remaining, o_remaining);
                    failed = 1'b1;
                end
                if (o_no_join !== e.no_join) begin
                    $error("no_join exp %0d got %0d", e.no_join, o_no_join); failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        requests_sent = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = 1'b0;
        i_first_cluster = '0;
        i_second_cluster = '0;
        i_distance_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        for (int i = 0; i < DEPTH; i++) dist_mem[i] = 0;
        for (int i = 0; i < NCL; i++) row_total[i] = 0;
        cfg_n = NCL;
        live_n = NCL;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(ROW_CFG, 0, 0, 0);
        add_row(ROW_LOAD, 0, 1, 65535);
        add_row(ROW_JOIN, 0, 0, 0, 1'b1, JOIN_MAX2);
        add_row(ROW_JOIN, 0, 0, 0, 1'b1, JOIN_NONE1);
        add_row(ROW_LOAD, 7, 7, 1234);
        add_row(ROW_JOIN, 0, 0, 0, 1'b1, JOIN_MAX2);
        add_row(ROW_LOAD, 31, 30, 43690);
        add_row(ROW_LOAD, 30, 31, 21845);
        add_row(ROW_CFG, 0, 0, 4);
        add_row(ROW_LOAD, 1, 0, 0);
        add_row(ROW_LOAD, 2, 0, 65535);
        add_row(ROW_LOAD, 0, 3, 1);
        add_row(ROW_LOAD, 1, 2, 32768);
        add_row(ROW_LOAD, 3, 1, 65535);
        add_row(ROW_LOAD, 3, 2, 0);
        add_row(ROW_JOIN, 0, 0, 0);
        add_row(ROW_JOIN, 0, 0, 0);
        add_row(ROW_JOIN, 0, 0, 0);
        add_row(ROW_JOIN, 0, 0, 0);
        add_row(ROW_CFG, 0, 0, 1);
        add_row(ROW_LOAD, 1, 0, 500);
        add_row(ROW_JOIN, 0, 0, 0);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: write_count(dir_rows[i].val);
                ROW_LOAD: load(dir_rows[i].f, dir_rows[i].s, dir_rows[i].val);
                default: send_request(ACT_JOIN, 0, 0, 0, dir_rows[i].typed,
                                      dir_rows[i].res);
            endcase
        end

        // one larger set, one or two joins
        run_set(16, 2);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = phase == 0 ? 0 : (phase == 1 ? 86 : 28);
            while (requests_sent < 200 + 50 * phase) begin
                int c;
                c = $urandom_range(2, 6);
                if ($urandom_range(9) == 0) c = $urandom_range(7, 10);
                if ($urandom_range(11) == 0) c = $urandom_range(1) ? 0 : 1;
                run_set(c, (c < 2 ? 2 : c) + 1);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (!failed && pending_joins.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ neighbor_joining_step.f @@
sv/nj_pkg.sv
sv/neighbor_joining_step.sv
verif/neighbor_joining_step_tb.sv
